### sv/ccc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_pkg: shared types and constants of the confusion counter
// Sizes, fixed-point constants, register and mode codes, helper functions.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int NUM_CLASSES = 16;
  localparam int VALUE_BITS  = 16;
  localparam int COUNT_BITS  = 32;

  localparam int POS_BITS  = $clog2(NUM_CLASSES);
  localparam int TC_BITS   = 4;
  localparam int IDX_BITS  = (POS_BITS > TC_BITS) ? POS_BITS : TC_BITS;
  localparam int OUT_BITS  = 32;
  localparam int CNT_EXT   = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
  localparam int FRAC_BITS = VALUE_BITS - 3;
  localparam int WIDE_BITS = VALUE_BITS + 2;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic        [VALUE_BITS-2:0] tol_t;
  typedef logic        [COUNT_BITS-1:0] count_t;
  typedef logic        [POS_BITS-1:0]   pos_t;
  typedef logic        [TC_BITS-1:0]    class_t;
  typedef logic        [OUT_BITS-1:0]   out_cnt_t;
  typedef logic        [1:0]            mode_t;
  typedef logic        [1:0]            reg_idx_t;

  // 0.5 and -1 in the value format
  localparam value_t Q_HALF      = value_t'(64'sd1 <<< (FRAC_BITS - 1));
  localparam value_t Q_MINUS_ONE = value_t'(-(64'sd1 <<< FRAC_BITS));

  localparam mode_t MODE_TOL   = 2'd0;
  localparam mode_t MODE_THR   = 2'd1;
  localparam mode_t MODE_CLASS = 2'd2;

  localparam reg_idx_t REG_MODE      = 2'd0;
  localparam reg_idx_t REG_TOLERANCE = 2'd1;
  localparam reg_idx_t REG_SEPARATOR = 2'd2;

  localparam mode_t  MODE_RESET      = MODE_CLASS;
  localparam tol_t   TOLERANCE_RESET = tol_t'(819);
  localparam value_t SEPARATOR_RESET = Q_HALF;

  // one-hot counter choice for an element, plus verdict spoiler
  typedef struct packed {
    logic tp;
    logic tn;
    logic fp;
    logic fn;
    logic spoil;
  } cat_t;

  function automatic count_t sat_inc(input count_t c);
    sat_inc = (c == {COUNT_BITS{1'b1}}) ? c : c + count_t'(1);
  endfunction

  function automatic out_cnt_t to_out(input count_t c);
    logic [CNT_EXT-1:0] w;
    w = CNT_EXT'(c);
    to_out = w[OUT_BITS-1:0];
  endfunction

endpackage

### sv/ccc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_if: item and result channels
// Valid/ready channels carrying one class element in, one count word out.
// ----------------------------------------------------------------------------
interface ccc_in_if import ccc_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   op;
  value_t output_value;
  value_t desired_value;
  class_t true_class;
  logic   last_element;

  modport source (output valid, output op, output output_value, output desired_value,
                  output true_class, output last_element, input ready);
  modport sink   (input valid, input op, input output_value, input desired_value,
                  input true_class, input last_element, output ready);
endinterface

interface ccc_out_if import ccc_pkg::*; ();
  logic     valid;
  logic     ready;
  class_t   class_index;
  out_cnt_t tp_value;
  out_cnt_t tn_value;
  out_cnt_t fp_value;
  out_cnt_t fn_value;
  logic     vector_done;
  logic     vector_correct;
  out_cnt_t well_total;
  out_cnt_t miss_total;

  modport source (output valid, output class_index, output tp_value, output tn_value,
                  output fp_value, output fn_value, output vector_done,
                  output vector_correct, output well_total, output miss_total,
                  input ready);
  modport sink   (input valid, input class_index, input tp_value, input tn_value,
                  input fp_value, input fn_value, input vector_done,
                  input vector_correct, input well_total, input miss_total,
                  output ready);
endinterface

### sv/ccc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_classify: per-element outcome decision
// Picks TP/TN/FP/FN for one element under the configured mode.
// ----------------------------------------------------------------------------
module ccc_classify import ccc_pkg::*; (
  input  mode_t  mode,
  input  tol_t   tolerance,
  input  value_t separator,
  input  value_t output_value,
  input  value_t desired_value,
  input  logic   is_true_class,
  output cat_t   cat
);

  logic signed [WIDE_BITS-1:0] o_w;
  logic signed [WIDE_BITS-1:0] d_w;
  logic signed [WIDE_BITS-1:0] t_w;
  logic above, below, o_pos, d_pos, hi;

  assign o_w = WIDE_BITS'(output_value);
  assign d_w = WIDE_BITS'(desired_value);
  assign t_w = $signed({{(WIDE_BITS-VALUE_BITS+1){1'b0}}, tolerance});

  assign above = o_w > (d_w + t_w);
  assign below = o_w <= (d_w - t_w);
  assign o_pos = output_value > separator;
  assign d_pos = desired_value > separator;
  assign hi    = output_value > Q_HALF;

  always_comb begin
    cat = '0;
    case (mode)
      MODE_TOL: begin
        // within band counts as true negative
        cat.fp = above;
        cat.fn = !above && below;
        cat.tn = !above && !below;
        cat.spoil = above || below;
      end
      MODE_THR: begin
        cat.tp = o_pos && d_pos;
        cat.tn = !o_pos && !d_pos;
        cat.fp = o_pos && !d_pos;
        cat.fn = !o_pos && d_pos;
        cat.spoil = o_pos != d_pos;
      end
      default: begin
        // class mode, spare code too
        cat.tp = is_true_class && hi;
        cat.fn = is_true_class && !hi;
        cat.fp = !is_true_class && hi;
        cat.tn = !is_true_class && !hi;
      end
    endcase
  end

endmodule

### sv/ccc_counter_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_counter_bank: per-class saturating confusion counters
// Four counters per class; one class read, and updated on upd, per cycle.
// ----------------------------------------------------------------------------
module ccc_counter_bank import ccc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   clear,
  input  logic   upd,
  input  pos_t   pos,
  input  cat_t   cat,
  output count_t tp_new,
  output count_t tn_new,
  output count_t fp_new,
  output count_t fn_new
);

  count_t tp_counts [NUM_CLASSES];
  count_t tn_counts [NUM_CLASSES];
  count_t fp_counts [NUM_CLASSES];
  count_t fn_counts [NUM_CLASSES];

  assign tp_new = cat.tp ? sat_inc(tp_counts[pos]) : tp_counts[pos];
  assign tn_new = cat.tn ? sat_inc(tn_counts[pos]) : tn_counts[pos];
  assign fp_new = cat.fp ? sat_inc(fp_counts[pos]) : fp_counts[pos];
  assign fn_new = cat.fn ? sat_inc(fn_counts[pos]) : fn_counts[pos];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        tp_counts[i] <= '0;
        tn_counts[i] <= '0;
        fp_counts[i] <= '0;
        fn_counts[i] <= '0;
      end
    end else if (upd) begin
      tp_counts[pos] <= tp_new;
      tn_counts[pos] <= tn_new;
      fp_counts[pos] <= fp_new;
      fn_counts[pos] <= fn_new;
    end
  end

endmodule

### sv/classifier_confusion_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// classifier_confusion_counter: streaming confusion matrix counter
// Counts per-class TP/TN/FP/FN and per-vector verdict totals.
//
//   channel  dir  handshake          word
//   item     in   valid/ready        op, output_value, desired_value,
//                                    true_class, last_element
//   result   out  valid/ready        class_index, tp/tn/fp/fn_value,
//                                    vector_done, vector_correct, totals
//   cfg      in   cfg_we, no stall   cfg_index, cfg_data
//
// One word per cycle unless result stalls; results follow in the next cycle.
// Counter read, saturating increment and write-back close in the accept cycle.
// Item ready stays high while the result register is empty or being drained.
// Synchronous reset clears all counters and vector state; no clearing pass.
// ----------------------------------------------------------------------------
module classifier_confusion_counter import ccc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  reg_idx_t  cfg_index,
  input  value_t    cfg_data,
  ccc_in_if.sink    item,
  ccc_out_if.source result
);

  mode_t  mode;
  tol_t   tolerance;
  value_t separator;

  count_t well_count, well_next;
  count_t miss_count, miss_next;
  pos_t   element_position;
  logic   vector_ok, vector_ok_next;
  value_t running_max, running_max_next;
  pos_t   max_position, max_position_next;
  logic   max_found, max_found_next;

  logic   accept, step, clr, done, correct, class_mode, max_upd;
  cat_t   cat;
  count_t tp_new, tn_new, fp_new, fn_new;
  logic [IDX_BITS-1:0] pos_ext, tc_ext, maxp_ext;
  logic [IDX_BITS-1:0] pos_idx;

  assign item.ready = !result.valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign step       = accept && !item.op;
  assign clr        = accept && item.op;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_RESET;
      tolerance <= TOLERANCE_RESET;
      separator <= SEPARATOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:      mode      <= cfg_data[1:0];
        REG_TOLERANCE: tolerance <= cfg_data[VALUE_BITS-2:0];
        REG_SEPARATOR: separator <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos_ext    = IDX_BITS'(element_position);
  assign tc_ext     = IDX_BITS'(item.true_class);
  assign class_mode = !(mode == MODE_TOL || mode == MODE_THR);

  ccc_classify u_classify (
    .mode          (mode),
    .tolerance     (tolerance),
    .separator     (separator),
    .output_value  (item.output_value),
    .desired_value (item.desired_value),
    .is_true_class (pos_ext == tc_ext),
    .cat           (cat)
  );

  ccc_counter_bank u_bank (
    .clk    (clk),
    .rst    (rst),
    .clear  (clr),
    .upd    (step),
    .pos    (element_position),
    .cat    (cat),
    .tp_new (tp_new),
    .tn_new (tn_new),
    .fp_new (fp_new),
    .fn_new (fn_new)
  );

  // strict running argmax, tracked in every mode
  assign max_upd           = running_max < item.output_value;
  assign running_max_next  = max_upd ? item.output_value : running_max;
  assign max_position_next = max_upd ? element_position : max_position;
  assign max_found_next    = max_found || max_upd;
  assign vector_ok_next    = vector_ok && !cat.spoil;
  assign maxp_ext          = IDX_BITS'(max_position_next);

  assign done    = item.last_element || (element_position == pos_t'(NUM_CLASSES - 1));
  assign correct = done && (class_mode ? (max_found_next && maxp_ext == tc_ext)
                                       : vector_ok_next);
  assign well_next = (done && correct)  ? sat_inc(well_count) : well_count;
  assign miss_next = (done && !correct) ? sat_inc(miss_count) : miss_count;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      well_count       <= '0;
      miss_count       <= '0;
      element_position <= '0;
      vector_ok        <= 1'b1;
      running_max      <= Q_MINUS_ONE;
      max_position     <= '0;
      max_found        <= 1'b0;
    end else if (step) begin
      well_count <= well_next;
      miss_count <= miss_next;
      if (done) begin
        element_position <= '0;
        vector_ok        <= 1'b1;
        running_max      <= Q_MINUS_ONE;
        max_position     <= '0;
        max_found        <= 1'b0;
      end else begin
        element_position <= element_position + pos_t'(1);
        vector_ok        <= vector_ok_next;
        running_max      <= running_max_next;
        max_position     <= max_position_next;
        max_found        <= max_found_next;
      end
    end
  end

  assign pos_idx = pos_ext;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      result.class_index    <= '0;
      result.tp_value       <= '0;
      result.tn_value       <= '0;
      result.fp_value       <= '0;
      result.fn_value       <= '0;
      result.vector_done    <= 1'b0;
      result.vector_correct <= 1'b0;
      result.well_total     <= '0;
      result.miss_total     <= '0;
    end else if (step) begin
      result.class_index    <= pos_idx[TC_BITS-1:0];
      result.tp_value       <= to_out(tp_new);
      result.tn_value       <= to_out(tn_new);
      result.fp_value       <= to_out(fp_new);
      result.fn_value       <= to_out(fn_new);
      result.vector_done    <= done;
      result.vector_correct <= correct;
      result.well_total     <= to_out(well_next);
      result.miss_total     <= to_out(miss_next);
    end
  end

endmodule
